// ----- rtl/core/ssa_pkg.sv -----
package ssa_pkg;

  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = 13;
  localparam int SUM_BITS    = 14;
  localparam int DEF_SHELVES = 32;
  localparam int DEF_SPANS   = 8;
  localparam logic [SIZE_BITS-1:0] SIDE = SIZE_BITS'(1) << COORD_BITS;
  localparam logic [SIZE_BITS-1:0] SHEET_RESET = 13'd1024;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [SIZE_BITS-1:0]  len;
  } span_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] a;
    logic [SUM_BITS-1:0] b;
    logic [SUM_BITS-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic                le;
    logic                eq;
  } alu_rsp_t;

endpackage

// ----- rtl/core/shelf_atlas_slot_allocator.sv -----
// Shelf-packing slot allocator. One request (allocate, release, clear) is
// taken at a time; in_ready is low until its result has been moved into the
// output register. An allocate skips shelves of another height, examines
// the free spans of a matching shelf, moves the later spans down when a span
// is used up, tries the fill point, and opens a new shelf if no shelf fits.
// A release searches the shelves, loads the stored spans, bubble sorts them
// through the shared compare unit, merges adjacent spans and writes them back.
// Span lists live in a RAM with registered read; the span compares and the
// edge sums of the sequencer go through the one shared adder/comparator.
// Clear empties the shelf table and also zeroes both sheet size registers.
module shelf_atlas_slot_allocator #(
  parameter int MAX_SHELVES = ssa_pkg::DEF_SHELVES,
  parameter int MAX_SPANS   = ssa_pkg::DEF_SPANS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [ssa_pkg::COORD_BITS-1:0] in_slot_x,
  input  logic [ssa_pkg::COORD_BITS-1:0] in_slot_y,
  input  logic [ssa_pkg::SIZE_BITS-1:0]  in_req_width,
  input  logic [ssa_pkg::SIZE_BITS-1:0]  in_req_height,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [ssa_pkg::COORD_BITS-1:0] out_got_x,
  output logic [ssa_pkg::COORD_BITS-1:0] out_got_y,
  output logic [ssa_pkg::SIZE_BITS-1:0]  out_got_width,
  output logic [ssa_pkg::SIZE_BITS-1:0]  out_got_height,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [ssa_pkg::SIZE_BITS-1:0]  cfg_data
);
  import ssa_pkg::*;

  localparam int SW    = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CW    = $clog2(MAX_SHELVES + 1);
  localparam int DEPTH = MAX_SHELVES * MAX_SPANS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(MAX_SPANS + 2);
  localparam int BX    = $clog2(MAX_SPANS + 1);
  localparam int SCW   = $clog2(MAX_SPANS + 1);
  localparam int NBUF  = MAX_SPANS + 1;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_A_SHELF = 14'b00000000000010,
    S_A_SPAN  = 14'b00000000000100,
    S_A_CHK   = 14'b00000000001000,
    S_A_SHIFT = 14'b00000000010000,
    S_A_SHW   = 14'b00000000100000,
    S_A_NEW   = 14'b00000001000000,
    S_R_FIND  = 14'b00000010000000,
    S_R_LOAD  = 14'b00000100000000,
    S_R_LDW   = 14'b00001000000000,
    S_R_SORT  = 14'b00010000000000,
    S_R_MERGE = 14'b00100000000000,
    S_R_WB    = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t st_r, st_nxt;

  logic [SIZE_BITS-1:0] sheet_w_r, sheet_w_nxt, sheet_h_r, sheet_h_nxt;
  logic [CW-1:0]        shelf_cnt_r, shelf_cnt_nxt;
  logic [SUM_BITS-1:0]  bottom_r, bottom_nxt;
  logic [CW-1:0]        s_r, s_nxt;
  logic [IW-1:0]        i_r, i_nxt, n_r, n_nxt, j_r, j_nxt, pass_r, pass_nxt, m_r, m_nxt;

  logic [COORD_BITS-1:0] sx_r, sy_r;
  logic [SIZE_BITS-1:0]  rw_r, rh_r;

  status_t               res_st_r, res_st_nxt;
  logic [COORD_BITS-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [SIZE_BITS-1:0]  res_w_r, res_w_nxt, res_h_r, res_h_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_st_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [SIZE_BITS-1:0]  out_w_r, out_h_r;

  logic [COORD_BITS-1:0] top_r  [MAX_SHELVES];
  logic [SIZE_BITS-1:0]  tall_r [MAX_SHELVES];
  logic [SIZE_BITS-1:0]  fill_r [MAX_SHELVES];
  logic [SCW-1:0]        scnt_r [MAX_SHELVES];
  span_t                 buf_r  [NBUF];

  // table write controls
  logic                  open_we, fill_we, scnt_we, scnt_clr;
  logic [SW-1:0]         open_idx;
  logic [SIZE_BITS-1:0]  fill_wdata;
  logic [SCW-1:0]        scnt_wdata;
  logic                  bwa_we, bwb_we;
  logic [BX-1:0]         bwa_idx, bwb_idx;
  span_t                 bwa_data, bwb_data;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  span_t                 mem_wdata, mem_rdata;

  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  logic [SIZE_BITS-1:0]  ew, eh;
  logic [SW-1:0]         si;
  logic                  in_xfer, cfg_xfer;
  span_t                 bj, bj1, bm1, bi;

  ssa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ssa_span_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [AW-1:0] span_addr(input logic [SW-1:0] s,
                                              input logic [IW-1:0] i);
    span_addr = AW'(s) * AW'(MAX_SPANS) + AW'(i);
  endfunction

  assign ew = (sheet_w_r > SIDE) ? SIDE : sheet_w_r;
  assign eh = (sheet_h_r > SIDE) ? SIDE : sheet_h_r;
  assign si = s_r[SW-1:0];

  assign in_ready  = (st_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid;

  assign bj  = buf_r[j_r[BX-1:0]];
  assign bj1 = buf_r[BX'(j_r + IW'(1))];
  assign bm1 = buf_r[BX'(m_r - IW'(1))];
  assign bi  = buf_r[i_r[BX-1:0]];

  always_comb begin
    st_nxt        = st_r;
    sheet_w_nxt   = sheet_w_r;
    sheet_h_nxt   = sheet_h_r;
    shelf_cnt_nxt = shelf_cnt_r;
    bottom_nxt    = bottom_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    pass_nxt      = pass_r;
    m_nxt         = m_r;
    res_st_nxt    = res_st_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_w_nxt     = res_w_r;
    res_h_nxt     = res_h_r;
    out_valid_nxt = out_valid_r && !out_ready;
    open_we       = 1'b0;
    open_idx      = shelf_cnt_r[SW-1:0];
    fill_we       = 1'b0;
    fill_wdata    = '0;
    scnt_we       = 1'b0;
    scnt_clr      = 1'b0;
    scnt_wdata    = '0;
    bwa_we        = 1'b0;
    bwa_idx       = '0;
    bwa_data      = '0;
    bwb_we        = 1'b0;
    bwb_idx       = '0;
    bwb_data      = '0;
    mem_we        = 1'b0;
    mem_waddr     = span_addr(si, i_r);
    mem_wdata     = '0;
    mem_raddr     = span_addr(si, i_r);
    alu_req       = '0;

    if (cfg_xfer) begin
      if (cfg_index == CFG_WIDTH) begin
        sheet_w_nxt = cfg_data;
      end else begin
        sheet_h_nxt = cfg_data;
      end
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_st_nxt = ST_OK;
          res_x_nxt  = '0;
          res_y_nxt  = '0;
          res_w_nxt  = '0;
          res_h_nxt  = '0;
          s_nxt      = '0;
          priority if (in_action == ACT_ALLOC) begin
            if (in_req_width == '0 || in_req_height == '0 ||
                in_req_width > ew || in_req_height > eh) begin
              res_st_nxt = ST_NOROOM;
              st_nxt     = S_DONE;
            end else begin
              st_nxt = S_A_SHELF;
            end
          end else if (in_action == ACT_RELEASE) begin
            if (in_req_width == '0 || in_req_height == '0 ||
                (SUM_BITS'(in_slot_x) + SUM_BITS'(in_req_width)) > SUM_BITS'(SIDE)) begin
              res_st_nxt = ST_IGNORED;
              st_nxt     = S_DONE;
            end else begin
              st_nxt = S_R_FIND;
            end
          end else if (in_action == ACT_CLEAR) begin
            shelf_cnt_nxt = '0;
            bottom_nxt    = '0;
            scnt_clr      = 1'b1;
            sheet_w_nxt   = '0;
            sheet_h_nxt   = '0;
            st_nxt        = S_DONE;
          end else begin
            res_st_nxt = ST_IGNORED;
            st_nxt     = S_DONE;
          end
        end
      end

      S_A_SHELF: begin
        if (s_r == shelf_cnt_r) begin
          st_nxt = S_A_NEW;
        end else if (tall_r[si] != rh_r) begin
          s_nxt = s_r + CW'(1);
        end else begin
          i_nxt  = '0;
          n_nxt  = IW'(scnt_r[si]);
          st_nxt = S_A_SPAN;
        end
      end

      S_A_SPAN: begin
        alu_req.a = SUM_BITS'(fill_r[si]);
        alu_req.b = SUM_BITS'(rw_r);
        alu_req.c = SUM_BITS'(ew);
        if (i_r < n_r) begin
          st_nxt = S_A_CHK;
        end else if (alu_rsp.le) begin
          fill_we    = 1'b1;
          fill_wdata = alu_rsp.sum[SIZE_BITS-1:0];
          res_x_nxt  = fill_r[si][COORD_BITS-1:0];
          res_y_nxt  = top_r[si];
          res_w_nxt  = rw_r;
          res_h_nxt  = rh_r;
          st_nxt     = S_DONE;
        end else begin
          s_nxt  = s_r + CW'(1);
          st_nxt = S_A_SHELF;
        end
      end

      S_A_CHK: begin
        // shared unit: rw <= len and rw == len
        alu_req.a = SUM_BITS'(rw_r);
        alu_req.c = SUM_BITS'(mem_rdata.len);
        if (!alu_rsp.le) begin
          i_nxt  = i_r + IW'(1);
          st_nxt = S_A_SPAN;
        end else if (alu_rsp.eq) begin
          res_x_nxt = mem_rdata.left;
          i_nxt     = i_r + IW'(1);
          st_nxt    = S_A_SHIFT;
        end else begin
          mem_we         = 1'b1;
          mem_wdata.left = mem_rdata.left + rw_r[COORD_BITS-1:0];
          mem_wdata.len  = mem_rdata.len - rw_r;
          res_x_nxt      = mem_rdata.left;
          res_y_nxt      = top_r[si];
          res_w_nxt      = rw_r;
          res_h_nxt      = rh_r;
          st_nxt         = S_DONE;
        end
      end

      S_A_SHIFT: begin
        if (i_r < n_r) begin
          st_nxt = S_A_SHW;
        end else begin
          scnt_we    = 1'b1;
          scnt_wdata = SCW'(n_r - IW'(1));
          res_y_nxt  = top_r[si];
          res_w_nxt  = rw_r;
          res_h_nxt  = rh_r;
          st_nxt     = S_DONE;
        end
      end

      S_A_SHW: begin
        mem_we    = 1'b1;
        mem_waddr = span_addr(si, i_r - IW'(1));
        mem_wdata = mem_rdata;
        i_nxt     = i_r + IW'(1);
        st_nxt    = S_A_SHIFT;
      end

      S_A_NEW: begin
        alu_req.a = bottom_r;
        alu_req.b = SUM_BITS'(rh_r);
        alu_req.c = SUM_BITS'(eh);
        if (!alu_rsp.le) begin
          res_st_nxt = ST_NOROOM;
        end else if (shelf_cnt_r == CW'(MAX_SHELVES)) begin
          res_st_nxt = ST_FULL;
        end else begin
          open_we       = 1'b1;
          shelf_cnt_nxt = shelf_cnt_r + CW'(1);
          bottom_nxt    = alu_rsp.sum;
          res_y_nxt     = bottom_r[COORD_BITS-1:0];
          res_w_nxt     = rw_r;
          res_h_nxt     = rh_r;
        end
        st_nxt = S_DONE;
      end

      S_R_FIND: begin
        if (s_r == shelf_cnt_r) begin
          res_st_nxt = ST_IGNORED;
          st_nxt     = S_DONE;
        end else if (top_r[si] == sy_r && tall_r[si] == rh_r) begin
          i_nxt  = '0;
          n_nxt  = IW'(scnt_r[si]);
          st_nxt = S_R_LOAD;
        end else begin
          s_nxt = s_r + CW'(1);
        end
      end

      S_R_LOAD: begin
        if (i_r < n_r) begin
          st_nxt = S_R_LDW;
        end else begin
          bwa_we        = 1'b1;
          bwa_idx       = n_r[BX-1:0];
          bwa_data.left = sx_r;
          bwa_data.len  = rw_r;
          n_nxt         = n_r + IW'(1);
          j_nxt         = '0;
          pass_nxt      = IW'(1);
          st_nxt        = S_R_SORT;
        end
      end

      S_R_LDW: begin
        bwa_we   = 1'b1;
        bwa_idx  = i_r[BX-1:0];
        bwa_data = mem_rdata;
        i_nxt    = i_r + IW'(1);
        st_nxt   = S_R_LOAD;
      end

      S_R_SORT: begin
        // bubble pass: swap when left[j] > left[j+1], which keeps ties in order
        alu_req.a = SUM_BITS'(bj.left);
        alu_req.c = SUM_BITS'(bj1.left);
        if (pass_r >= n_r) begin
          m_nxt  = IW'(1);
          i_nxt  = IW'(1);
          st_nxt = S_R_MERGE;
        end else if (j_r + IW'(1) < n_r) begin
          if (!alu_rsp.le) begin
            bwa_we   = 1'b1;
            bwa_idx  = j_r[BX-1:0];
            bwa_data = bj1;
            bwb_we   = 1'b1;
            bwb_idx  = BX'(j_r + IW'(1));
            bwb_data = bj;
          end
          j_nxt = j_r + IW'(1);
        end else begin
          j_nxt    = '0;
          pass_nxt = pass_r + IW'(1);
        end
      end

      S_R_MERGE: begin
        alu_req.a = SUM_BITS'(bm1.left);
        alu_req.b = SUM_BITS'(bm1.len);
        alu_req.c = SUM_BITS'(bi.left);
        if (i_r < n_r) begin
          if (alu_rsp.eq) begin
            bwa_we        = 1'b1;
            bwa_idx       = BX'(m_r - IW'(1));
            bwa_data.left = bm1.left;
            bwa_data.len  = bm1.len + bi.len;
          end else begin
            bwa_we   = 1'b1;
            bwa_idx  = m_r[BX-1:0];
            bwa_data = bi;
            m_nxt    = m_r + IW'(1);
          end
          i_nxt = i_r + IW'(1);
        end else if (m_r > IW'(MAX_SPANS)) begin
          res_st_nxt = ST_FULL;
          st_nxt     = S_DONE;
        end else begin
          i_nxt  = '0;
          st_nxt = S_R_WB;
        end
      end

      S_R_WB: begin
        if (i_r < m_r) begin
          mem_we    = 1'b1;
          mem_wdata = bi;
          i_nxt     = i_r + IW'(1);
        end else begin
          scnt_we    = 1'b1;
          scnt_wdata = SCW'(m_r);
          st_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      sheet_w_r   <= SHEET_RESET;
      sheet_h_r   <= SHEET_RESET;
      shelf_cnt_r <= '0;
      bottom_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sheet_w_r   <= sheet_w_nxt;
      sheet_h_r   <= sheet_h_nxt;
      shelf_cnt_r <= shelf_cnt_nxt;
      bottom_r    <= bottom_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r      <= s_nxt;
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    j_r      <= j_nxt;
    pass_r   <= pass_nxt;
    m_r      <= m_nxt;
    res_st_r <= res_st_nxt;
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
    res_w_r  <= res_w_nxt;
    res_h_r  <= res_h_nxt;
    if (in_xfer) begin
      sx_r <= in_slot_x;
      sy_r <= in_slot_y;
      rw_r <= in_req_width;
      rh_r <= in_req_height;
    end
    if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_st_r <= res_st_r;
      out_x_r  <= res_x_r;
      out_y_r  <= res_y_r;
      out_w_r  <= res_w_r;
      out_h_r  <= res_h_r;
    end
  end

  // shelf table: written at the open index or the current scan index
  always_ff @(posedge clk) begin
    if (open_we) begin
      top_r[open_idx]  <= bottom_r[COORD_BITS-1:0];
      tall_r[open_idx] <= rh_r;
      fill_r[open_idx] <= rw_r;
    end
    if (fill_we) begin
      fill_r[si] <= fill_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || scnt_clr) begin
      for (int k = 0; k < MAX_SHELVES; k++) begin
        scnt_r[k] <= '0;
      end
    end else if (open_we) begin
      scnt_r[open_idx] <= '0;
    end else if (scnt_we) begin
      scnt_r[si] <= scnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (bwa_we) begin
      buf_r[bwa_idx] <= bwa_data;
    end
    if (bwb_we) begin
      buf_r[bwb_idx] <= bwb_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_st_r;
  assign out_got_x      = out_x_r;
  assign out_got_y      = out_y_r;
  assign out_got_width  = out_w_r;
  assign out_got_height = out_h_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    shelf_cnt_r <= CW'(MAX_SHELVES))
    else $error("shelf count past table size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second request taken while busy");

  a_empty_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    shelf_cnt_r == '0 |-> bottom_r == '0)
    else $error("bottom edge set with no shelves");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE && !out_valid_r |=> out_valid_r && in_ready)
    else $error("result not presented after completion");

endmodule

// ----- rtl/core/ssa_alu.sv -----
module ssa_alu (
  input  ssa_pkg::alu_req_t req,
  output ssa_pkg::alu_rsp_t rsp
);
  import ssa_pkg::*;

  logic [SUM_BITS-1:0] sum;

  assign sum     = req.a + req.b;
  assign rsp.sum = sum;
  assign rsp.le  = (sum <= req.c);
  assign rsp.eq  = (sum == req.c);

endmodule

// ----- rtl/core/ssa_span_mem.sv -----
module ssa_span_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  ssa_pkg::span_t        wdata,
  input  logic [AW-1:0]         raddr,
  output ssa_pkg::span_t        rdata
);
  import ssa_pkg::*;

  span_t mem [DEPTH];
  span_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ssa_pkg::*;

  localparam int SHELVES   = 32;
  localparam int SPANS     = 8;
  localparam int CYC_LIMIT = 600000;

  typedef struct {
    logic [1:0]            act;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
  } slot_req_t;

  typedef struct {
    status_t               st;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
  } slot_grant_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_action;
  logic [COORD_BITS-1:0] in_slot_x;
  logic [COORD_BITS-1:0] in_slot_y;
  logic [SIZE_BITS-1:0]  in_req_width;
  logic [SIZE_BITS-1:0]  in_req_height;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_status;
  logic [COORD_BITS-1:0] out_got_x;
  logic [COORD_BITS-1:0] out_got_y;
  logic [SIZE_BITS-1:0]  out_got_width;
  logic [SIZE_BITS-1:0]  out_got_height;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [SIZE_BITS-1:0]  cfg_data;

  shelf_atlas_slot_allocator uut (.*);

  // shadow copy of the allocator tables
  int sheet_w, sheet_h, n_shelves;
  int top_of[SHELVES], tall_of[SHELVES], fill_of[SHELVES], n_free[SHELVES];
  int free_x[SHELVES][SPANS], free_len[SHELVES][SPANS];

  slot_grant_t grants_due[$];
  slot_req_t   live_slots[$];
  int          errors;
  int          cycles;
  bit          quiet;

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("shelf_atlas_slot_allocator regression: fail");
      $finish;
    end
  end

  function automatic slot_grant_t grant(status_t st, int x, int y, int w, int h);
    slot_grant_t g;
    g.st = st;
    g.x  = x[COORD_BITS-1:0];
    g.y  = y[COORD_BITS-1:0];
    g.w  = w[SIZE_BITS-1:0];
    g.h  = h[SIZE_BITS-1:0];
    return g;
  endfunction

  function automatic slot_grant_t place_slot(int rw, int rh);
    int ew, eh, x, len, y, s;
    ew = sheet_w > SIDE ? SIDE : sheet_w;
    eh = sheet_h > SIDE ? SIDE : sheet_h;
    if (rw == 0 || rh == 0 || rw > ew || rh > eh) return grant(ST_NOROOM, 0, 0, 0, 0);
    for (s = 0; s < n_shelves; s++) begin
      if (tall_of[s] != rh) continue;
      for (int i = 0; i < n_free[s]; i++) begin
        x   = free_x[s][i];
        len = free_len[s][i];
        if (len < rw) continue;
        if (len > rw) begin
          free_x[s][i]   = (x + rw) & 12'hfff;
          free_len[s][i] = len - rw;
        end else begin
          for (int k = i + 1; k < n_free[s]; k++) begin
            free_x[s][k-1]   = free_x[s][k];
            free_len[s][k-1] = free_len[s][k];
          end
          n_free[s]--;
        end
        return grant(ST_OK, x, top_of[s], rw, rh);
      end
      if (fill_of[s] + rw <= ew) begin
        x = fill_of[s];
        fill_of[s] = x + rw;
        return grant(ST_OK, x, top_of[s], rw, rh);
      end
    end
    y = n_shelves > 0 ? top_of[n_shelves-1] + tall_of[n_shelves-1] : 0;
    if (y + rh > eh) return grant(ST_NOROOM, 0, 0, 0, 0);
    if (n_shelves >= SHELVES) return grant(ST_FULL, 0, 0, 0, 0);
    top_of[n_shelves]  = y;
    tall_of[n_shelves] = rh;
    fill_of[n_shelves] = rw;
    n_free[n_shelves]  = 0;
    n_shelves++;
    return grant(ST_OK, 0, y, rw, rh);
  endfunction

  function automatic slot_grant_t return_slot(int sx, int sy, int rw, int rh);
    int tl[SPANS+1], tn[SPANS+1];
    int s, n, m, kl, kn, j;
    if (rw == 0 || rh == 0 || sx + rw > SIDE) return grant(ST_IGNORED, 0, 0, 0, 0);
    for (s = 0; s < n_shelves; s++)
      if (top_of[s] == sy && tall_of[s] == rh) break;
    if (s >= n_shelves) return grant(ST_IGNORED, 0, 0, 0, 0);
    n = n_free[s];
    for (int i = 0; i < n; i++) begin
      tl[i] = free_x[s][i];
      tn[i] = free_len[s][i];
    end
    tl[n] = sx;
    tn[n] = rw;
    n++;
    for (int i = 1; i < n; i++) begin
      kl = tl[i];
      kn = tn[i];
      j  = i;
      while (j > 0 && tl[j-1] > kl) begin
        tl[j] = tl[j-1];
        tn[j] = tn[j-1];
        j--;
      end
      tl[j] = kl;
      tn[j] = kn;
    end
    m = 1;
    for (int i = 1; i < n; i++) begin
      if (tl[m-1] + tn[m-1] == tl[i]) tn[m-1] += tn[i];
      else begin
        tl[m] = tl[i];
        tn[m] = tn[i];
        m++;
      end
    end
    if (m > SPANS) return grant(ST_FULL, 0, 0, 0, 0);
    for (int i = 0; i < m; i++) begin
      free_x[s][i]   = tl[i] & 12'hfff;
      free_len[s][i] = tn[i] & 13'h1fff;
    end
    n_free[s] = m;
    return grant(ST_OK, 0, 0, 0, 0);
  endfunction

  function automatic slot_grant_t predict_grant(slot_req_t r);
    case (r.act)
      ACT_ALLOC:   return place_slot(r.w, r.h);
      ACT_RELEASE: return return_slot(r.x, r.y, r.w, r.h);
      ACT_CLEAR: begin
        n_shelves = 0;
        foreach (n_free[s]) n_free[s] = 0;
        sheet_w = 0;
        sheet_h = 0;
        return grant(ST_OK, 0, 0, 0, 0);
      end
      default:     return grant(ST_IGNORED, 0, 0, 0, 0);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    slot_grant_t g;
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) report_mismatch("unexpected result", out_status, -1);
      else begin
        g = grants_due.pop_front();
        if (out_status != g.st) report_mismatch("status", out_status, g.st);
        if (out_got_x != g.x) report_mismatch("got_x", out_got_x, g.x);
        if (out_got_y != g.y) report_mismatch("got_y", out_got_y, g.y);
        if (out_got_width != g.w) report_mismatch("got_width", out_got_width, g.w);
        if (out_got_height != g.h) report_mismatch("got_height", out_got_height, g.h);
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    int hold;
    if (hold > 0) hold--;
    if (quiet) out_ready = 1'b1;
    else if (hold == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 4);
      end else out_ready = 1'b1;
    end
  end

  task automatic send_item(logic [1:0] act, int x, int y, int w, int h);
    slot_req_t   r;
    slot_grant_t g;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    r.act = act;
    r.x   = x[COORD_BITS-1:0];
    r.y   = y[COORD_BITS-1:0];
    r.w   = w[SIZE_BITS-1:0];
    r.h   = h[SIZE_BITS-1:0];
    in_action     = r.act;
    in_slot_x     = r.x;
    in_slot_y     = r.y;
    in_req_width  = r.w;
    in_req_height = r.h;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    g = predict_grant(r);
    grants_due = {grants_due, g};
    if (act == ACT_ALLOC && g.st == ST_OK) begin
      r.act = ACT_RELEASE;
      r.x = g.x;
      r.y = g.y;
      live_slots = {live_slots, r};
    end
    if (act == ACT_CLEAR) live_slots.delete();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (grants_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    drain();
    cfg_index = idx;
    cfg_data  = value[SIZE_BITS-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) sheet_w = value & 13'h1fff;
    else sheet_h = value & 13'h1fff;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    write_reg(CFG_WIDTH, 4096);
    write_reg(CFG_HEIGHT, 4096);
    send_item(ACT_ALLOC, 0, 0, 0, 8);
    send_item(ACT_ALLOC, 0, 0, 8, 0);
    send_item(ACT_ALLOC, 0, 0, 4097, 8);
    send_item(ACT_ALLOC, 0, 0, 4096, 1);
    send_item(ACT_ALLOC, 0, 0, 100, 16);
    send_item(ACT_ALLOC, 0, 0, 50, 16);
    send_item(ACT_ALLOC, 0, 0, 30, 16);
    send_item(ACT_RELEASE, 100, 1, 50, 16);
    send_item(ACT_RELEASE, 0, 1, 100, 16);
    send_item(ACT_ALLOC, 0, 0, 20, 16);
    send_item(ACT_ALLOC, 0, 0, 130, 16);
    send_item(ACT_RELEASE, 4095, 1, 2, 16);
    send_item(ACT_RELEASE, 0, 1, 0, 16);
    send_item(ACT_RELEASE, 0, 5, 10, 16);
    send_item(ACT_NONE, 4095, 4095, 4096, 4096);
    send_item(ACT_ALLOC, 0, 0, 10, 4079);
    send_item(ACT_ALLOC, 0, 0, 10, 4000);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    send_item(ACT_ALLOC, 0, 0, 1, 1);
    write_reg(CFG_WIDTH, 8191);
    write_reg(CFG_HEIGHT, 6000);
    send_item(ACT_ALLOC, 0, 0, 4096, 4096);
    send_item(ACT_ALLOC, 0, 0, 1, 1);
  endtask

  // one shelf per height until the table runs out
  task automatic test_shelf_table_full();
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    write_reg(CFG_WIDTH, 64);
    write_reg(CFG_HEIGHT, 4096);
    for (int i = 1; i <= SHELVES + 1; i++) send_item(ACT_ALLOC, 0, 0, 8, i);
  endtask

  // every other slot back to the same shelf: the ninth gap overflows the list
  task automatic test_span_list_full();
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    write_reg(CFG_WIDTH, 1024);
    write_reg(CFG_HEIGHT, 1024);
    for (int i = 0; i < 17; i++) send_item(ACT_ALLOC, 0, 0, 2, 4);
    for (int i = 0; i < 9; i++) send_item(ACT_RELEASE, 4 * i, 0, 2, 4);
  endtask

  task automatic test_random();
    int pick, k, ext;
    slot_req_t r;
    int sizes[6] = '{0, 1, 17, 1024, 4096, 8191};
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) quiet = 1'b1;
      send_item(ACT_CLEAR, 0, 0, 0, 0);
      ext = phase < 6 ? sizes[phase] : $urandom_range(200, 4096);
      write_reg(CFG_WIDTH, phase == 0 ? 1024 : (phase % 2 ? ext : $urandom_range(64, 2048)));
      write_reg(CFG_HEIGHT, phase == 0 ? 1024 : (phase % 2 ? $urandom_range(64, 4096) : ext));
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          send_item(ACT_ALLOC, $urandom, $urandom, $urandom_range(0, 9) == 0 ?
                    $urandom_range(0, 4096) : $urandom_range(1, 120),
                    $urandom_range(0, 19) == 0 ? $urandom_range(0, 4096) :
                    $urandom_range(1, 6) * 4);
        else if (pick < 85 && live_slots.size() != 0) begin
          k = $urandom_range(0, live_slots.size() - 1);
          r = live_slots[k];
          live_slots.delete(k);
          send_item(ACT_RELEASE, r.x, r.y, r.w, r.h);
        end else if (pick < 96)
          send_item(ACT_RELEASE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4096), $urandom_range(0, 4096));
        else if (pick < 98) send_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
        else send_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_ALLOC;
    in_slot_x = '0;
    in_slot_y = '0;
    in_req_width = '0;
    in_req_height = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    sheet_w = SHEET_RESET;
    sheet_h = SHEET_RESET;
    n_shelves = 0;
    foreach (n_free[s]) n_free[s] = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_shelf_table_full();
    test_span_list_full();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("shelf_atlas_slot_allocator regression: pass");
    else $display("shelf_atlas_slot_allocator regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ssa_pkg.sv
rtl/core/ssa_alu.sv
rtl/core/ssa_span_mem.sv
rtl/core/shelf_atlas_slot_allocator.sv
tb/sv/tb.sv
